/* rtl/core/rfcc_pkg.sv */
// Shared types, character codes and CRC step function for the radio frame CRC checker.
package rfcc_pkg;

   localparam logic [7:0]  CHAR_DOLLAR = 8'h24;
   localparam logic [7:0]  CHAR_HASH   = 8'h23;
   localparam logic [7:0]  CHAR_STAR   = 8'h2A;
   localparam logic [7:0]  CHAR_COMMA  = 8'h2C;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_NINE   = 8'h39;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [2:0]  MAX_DIGITS  = 3'd5;

   localparam int          QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] byte_val;
      logic       is_dollar;
      logic       is_hash;
      logic       is_star;
      logic       is_comma;
      logic       is_digit;
      logic [3:0] digit;
   } class_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/rfcc_front.sv */
// Front end: accepts received bytes and classifies them for the frame engine.
module rfcc_front
   import rfcc_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       queue_full,
   output logic       push,
   output class_type  push_data
);

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data           = '0;
      push_data.byte_val  = req_rx_byte;
      push_data.is_dollar = (req_rx_byte == CHAR_DOLLAR);
      push_data.is_hash   = (req_rx_byte == CHAR_HASH);
      push_data.is_star   = (req_rx_byte == CHAR_STAR);
      push_data.is_comma  = (req_rx_byte == CHAR_COMMA);
      push_data.is_digit  = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);
      push_data.digit     = 4'(req_rx_byte - CHAR_ZERO);
   end

endmodule

/* rtl/core/rfcc_queue.sv */
// Two-entry queue of classified bytes between front end and frame engine.
module rfcc_queue
   import rfcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output class_type head
);

   class_type   entry_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full  = (count_ff == 2'(QUEUE_DEPTH));
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/rfcc_back.sv */
// Frame engine: tracks frame state, runs the CRC and checks the decimal trailer.
module rfcc_back
   import rfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        queue_empty,
   input  class_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_in_frame,
   output logic        rsp_frame_end,
   output logic        rsp_frame_good,
   output logic [15:0] rsp_crc_value
);

   logic        frame_open_ff, frame_open_in;
   logic [1:0]  comma_count_ff, comma_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [16:0] trailer_value_ff, trailer_value_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   logic        star_seen_ff, star_seen_in;
   logic        trailer_bad_ff, trailer_bad_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_out_ff;
   logic        in_frame_ff, in_frame_in;
   logic        frame_end_ff, frame_end_in;
   logic        frame_good_ff, frame_good_in;
   logic [15:0] crc_value_ff;
   logic [16:0] times_ten;

   assign pop            = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_out   = byte_out_ff;
   assign rsp_in_frame   = in_frame_ff;
   assign rsp_frame_end  = frame_end_ff;
   assign rsp_frame_good = frame_good_ff;
   assign rsp_crc_value  = crc_value_ff;

   assign times_ten = {trailer_value_ff[13:0], 3'b000} + {trailer_value_ff[15:0], 1'b0};

   always_comb begin
      frame_open_in    = frame_open_ff;
      comma_count_in   = comma_count_ff;
      crc_in           = crc_ff;
      trailer_value_in = trailer_value_ff;
      digit_count_in   = digit_count_ff;
      star_seen_in     = star_seen_ff;
      trailer_bad_in   = trailer_bad_ff;
      in_frame_in      = 1'b0;
      frame_end_in     = 1'b0;
      frame_good_in    = 1'b0;
      rsp_valid_in     = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (head.is_dollar) begin
            frame_open_in    = 1'b1;
            comma_count_in   = 2'd0;
            crc_in           = 16'h0000;
            trailer_value_in = '0;
            digit_count_in   = 3'd0;
            star_seen_in     = 1'b0;
            trailer_bad_in   = 1'b0;
            in_frame_in      = 1'b1;
         end else if (frame_open_ff) begin
            in_frame_in = 1'b1;
            priority if (head.is_hash) begin
               frame_end_in  = 1'b1;
               frame_good_in = (comma_count_ff == 2'd2) && star_seen_ff && !trailer_bad_ff &&
                               (digit_count_ff != 3'd0) &&
                               (trailer_value_ff == {1'b0, crc_ff});
               frame_open_in = 1'b0;
            end else if (comma_count_ff == 2'd0) begin
               if (head.is_comma) begin
                  comma_count_in = 2'd1;
               end
            end else if (comma_count_ff == 2'd1) begin
               if (head.is_comma) begin
                  comma_count_in = 2'd2;
               end else begin
                  crc_in = crc_byte(crc_ff, head.byte_val);
               end
            end else begin
               priority if (star_seen_ff) begin
                  trailer_bad_in = 1'b1;
               end else if (head.is_star) begin
                  if (digit_count_ff == 3'd0) begin
                     trailer_bad_in = 1'b1;
                  end
                  star_seen_in = 1'b1;
               end else if (head.is_digit) begin
                  if (digit_count_ff >= MAX_DIGITS) begin
                     trailer_bad_in = 1'b1;
                  end else begin
                     if ((digit_count_ff == 3'd1) && (trailer_value_ff == '0)) begin
                        trailer_bad_in = 1'b1;
                     end
                     trailer_value_in = times_ten + {13'd0, head.digit};
                     digit_count_in   = digit_count_ff + 3'd1;
                  end
               end else begin
                  trailer_bad_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff    <= 1'b0;
         comma_count_ff   <= 2'd0;
         crc_ff           <= 16'h0000;
         trailer_value_ff <= '0;
         digit_count_ff   <= 3'd0;
         star_seen_ff     <= 1'b0;
         trailer_bad_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_open_ff    <= frame_open_in;
         comma_count_ff   <= comma_count_in;
         crc_ff           <= crc_in;
         trailer_value_ff <= trailer_value_in;
         digit_count_ff   <= digit_count_in;
         star_seen_ff     <= star_seen_in;
         trailer_bad_ff   <= trailer_bad_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_out_ff   <= head.byte_val;
         in_frame_ff   <= in_frame_in;
         frame_end_ff  <= frame_end_in;
         frame_good_ff <= frame_good_in;
         crc_value_ff  <= crc_in;
      end
   end

endmodule

/* rtl/core/radio_frame_crc_checker_core.sv */
// Top level of the radio frame CRC checker: front end, queue and frame engine.
// Usage:
//   The req_ channel takes one received byte per transaction (req_rx_byte).
//   The rsp_ channel returns exactly one transaction per byte, in order: the
//   byte itself, whether it belongs to a frame, whether it is the closing '#',
//   the frame verdict on that '#', and the CRC-16 after the byte.
//   A '$' opens a frame; the CRC runs over the bytes between the first and
//   second comma, and the decimal trailer before "*#" must equal it.
// Flow: a byte accepted on the req_ channel is written into the queue; the
//   frame engine pops it into the output register, which raises rsp_valid,
//   as soon as that register is empty or being taken (rsp_ready high).
// Throughput: one byte per cycle sustained while rsp_ready stays high; the
//   frame engine updates its state and the CRC for a whole byte at once.
// Reset: synchronous, active high; closes any frame, clears the CRC and
//   empties the queue and output register.
// Stall: while rsp_ready is low a valid output register holds; the two-entry
//   queue keeps taking bytes until it fills, then req_ready drops.
module radio_frame_crc_checker_core
   import rfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_in_frame,
   output logic        rsp_frame_end,
   output logic        rsp_frame_good,
   output logic [15:0] rsp_crc_value
);

   logic      queue_full;
   logic      queue_empty;
   logic      push;
   logic      pop;
   class_type push_data;
   class_type head;

   rfcc_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   rfcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   rfcc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_in_frame   (rsp_in_frame),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_frame_good (rsp_frame_good),
      .rsp_crc_value  (rsp_crc_value)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the radio frame CRC checker core.
module testbench
   import rfcc_pkg::*;
();

   typedef struct {
      logic [7:0]  byte_out;
      logic        in_frame;
      logic        frame_end;
      logic        frame_good;
      logic [15:0] crc_value;
   } verdict_type;

   typedef enum int {
      WELL_FORMED, OFF_BY_ONE, LEADING_ZERO, EXTRA_DIGIT, NO_STAR, TWO_STARS,
      JUNK_AFTER_STAR, THIRD_COMMA, ONE_COMMA, NO_COMMA, CUT_SHORT, WRAPPED_VALUE,
      JUNK_TRAILER, BARE_STAR
   } frame_flaw_type;

   class crc_frame_tracker;
      bit          open_frame;
      bit [1:0]    commas;
      bit [15:0]   crc_acc;
      bit [16:0]   trailer_num;
      bit [2:0]    digits_seen;
      bit          star_hit;
      bit          trailer_broken;
      verdict_type pending_verdicts[$];
      int          errors;
      int          frames_closed;
      int          frames_good;
      int          bytes_taken;

      static function bit [15:0] crc16_step(bit [15:0] acc, bit [7:0] b);
         bit [15:0] r;
         bit        fb;
         r = acc;
         for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r = {r[14:0], 1'b0};
            if (fb) r = r ^ CRC_POLY;
         end
         return r;
      endfunction

      function void take_byte(bit [7:0] b);
         verdict_type v;
         v.byte_out = b;
         v.in_frame = 0;
         v.frame_end = 0;
         v.frame_good = 0;
         bytes_taken++;
         if (b == CHAR_DOLLAR) begin
            open_frame = 1;
            commas = 0;
            crc_acc = 0;
            trailer_num = 0;
            digits_seen = 0;
            star_hit = 0;
            trailer_broken = 0;
            v.in_frame = 1;
         end else if (open_frame) begin
            v.in_frame = 1;
            if (b == CHAR_HASH) begin
               v.frame_end = 1;
               v.frame_good = commas == 2 && star_hit && !trailer_broken &&
                              digits_seen != 0 && trailer_num == {1'b0, crc_acc};
               open_frame = 0;
               frames_closed++;
               if (v.frame_good) frames_good++;
            end else if (commas == 0) begin
               if (b == CHAR_COMMA) commas = 1;
            end else if (commas == 1) begin
               if (b == CHAR_COMMA) commas = 2;
               else crc_acc = crc16_step(crc_acc, b);
            end else if (star_hit) begin
               trailer_broken = 1;
            end else if (b == CHAR_STAR) begin
               if (digits_seen == 0) trailer_broken = 1;
               star_hit = 1;
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               if (digits_seen >= MAX_DIGITS) begin
                  trailer_broken = 1;
               end else begin
                  if (digits_seen == 1 && trailer_num == 0) trailer_broken = 1;
                  trailer_num = 17'(trailer_num * 10 + (b - CHAR_ZERO));
                  digits_seen++;
               end
            end else begin
               trailer_broken = 1;
            end
         end
         v.crc_value = crc_acc;
         pending_verdicts.push_back(v);
      endfunction

      function void match_response(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("response for byte %h with no transaction pending", got.byte_out);
            errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.byte_out !== want.byte_out) begin
            $error("byte_out: expected %h, got %h", want.byte_out, got.byte_out);
            errors++;
         end
         if (got.in_frame !== want.in_frame) begin
            $error("in_frame: expected %b, got %b", want.in_frame, got.in_frame);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, got.frame_end);
            errors++;
         end
         if (got.frame_good !== want.frame_good) begin
            $error("frame_good: expected %b, got %b", want.frame_good, got.frame_good);
            errors++;
         end
         if (got.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, got %h", want.crc_value, got.crc_value);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_byte_out;
   logic        rsp_in_frame;
   logic        rsp_frame_end;
   logic        rsp_frame_good;
   logic [15:0] rsp_crc_value;

   logic [7:0]       rx_stream[$];
   crc_frame_tracker tracker;
   verdict_type      seen_rsp;

   radio_frame_crc_checker_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_in_frame   (rsp_in_frame),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_frame_good (rsp_frame_good),
      .rsp_crc_value  (rsp_crc_value)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) rx_stream.push_back(s[i]);
   endfunction

   function automatic bit [7:0] plain_byte(bit marks_ok);
      bit [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == CHAR_DOLLAR ||
                 (!marks_ok && (b == CHAR_HASH || b == CHAR_COMMA)));
      return b;
   endfunction

   function automatic void add_random_frame();
      bit [7:0]       payload[$];
      bit [15:0]      crc;
      frame_flaw_type flaw;
      int unsigned    value;
      crc = 0;
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(3, 1)) rx_stream.push_back(plain_byte(1));
      if ($urandom_range(99) < 65) flaw = WELL_FORMED;
      else flaw = frame_flaw_type'($urandom_range(BARE_STAR, OFF_BY_ONE));
      rx_stream.push_back(CHAR_DOLLAR);
      repeat ($urandom_range(3)) rx_stream.push_back(plain_byte(0));
      if (flaw != NO_COMMA) rx_stream.push_back(CHAR_COMMA);
      repeat ($urandom_range(6)) payload.push_back(plain_byte(0));
      foreach (payload[i]) begin
         crc = crc_frame_tracker::crc16_step(crc, payload[i]);
         rx_stream.push_back(payload[i]);
      end
      if (flaw == ONE_COMMA || flaw == NO_COMMA) begin
         push_text($sformatf("%0d*#", crc));
         return;
      end
      if (flaw == CUT_SHORT) return;
      rx_stream.push_back(CHAR_COMMA);
      value = crc;
      if (flaw == OFF_BY_ONE) value = crc + 1;
      if (flaw == WRAPPED_VALUE) value = (crc <= 34463) ? crc + 65536 : crc + 7;
      case (flaw)
         LEADING_ZERO: push_text($sformatf("0%0d*#", value));
         EXTRA_DIGIT: push_text($sformatf("%0d%0d*#", value, $urandom_range(9)));
         NO_STAR: push_text($sformatf("%0d#", value));
         TWO_STARS: push_text($sformatf("%0d**#", value));
         JUNK_AFTER_STAR: begin
            push_text($sformatf("%0d*", value));
            rx_stream.push_back(plain_byte(0));
            rx_stream.push_back(CHAR_HASH);
         end
         THIRD_COMMA: push_text($sformatf("%0d,*#", value));
         JUNK_TRAILER: begin
            repeat ($urandom_range(4, 1)) rx_stream.push_back(plain_byte(1));
            rx_stream.push_back(CHAR_HASH);
         end
         BARE_STAR: push_text("*#");
         default: push_text($sformatf("%0d*#", value));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit may_idle);
      while (may_idle && $urandom_range(99) < 19) begin
         req_valid <= 0;
         req_rx_byte <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid <= 1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.take_byte(b);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen_rsp.byte_out = rsp_byte_out;
         seen_rsp.in_frame = rsp_in_frame;
         seen_rsp.frame_end = rsp_frame_end;
         seen_rsp.frame_good = rsp_frame_good;
         seen_rsp.crc_value = rsp_crc_value;
         tracker.match_response(seen_rsp);
      end
   end

   initial begin
      int cyc;
      cyc = 0;
      @(negedge reset);
      forever begin
         if (cyc >= 400 && cyc < 460) rsp_ready <= 0;
         else if (cyc >= 900 && cyc < 1300) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(99) >= 19);
         cyc++;
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_rx_byte = 0;
      rsp_ready = 0;
      tracker = new;
      push_text("#");
      rx_stream.push_back(8'hFF);
      push_text("$,");
      rx_stream.push_back(8'h00);
      push_text(",0*#");
      push_text("$$,,01*#$,,*#$h,,5#");
      while (rx_stream.size() < 1330) add_random_frame();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (rx_stream[i]) send_byte(rx_stream[i], i < 500 || i >= 800);
      req_valid <= 0;
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Streamed %0d bytes: %0d frames closed, %0d of them with a matching CRC.",
               tracker.bytes_taken, tracker.frames_closed, tracker.frames_good);
      $display("Mix: clean frames, malformed trailers and commas, stray bytes, backpressure.");
      if (tracker.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
